// ===== rtl/pls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// shared sizes, codes and beat types of the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY = 64;
  // address of one stored element
  localparam int AW = $clog2(CAPACITY);
  // element count, holds 0..CAPACITY
  localparam int CW = $clog2(CAPACITY + 1);
  // common width for comparing position against count
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int TOTAL_W = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic                    kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [TOTAL_W-1:0]      element_total;
  } out_beat_t;

  // finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } pls_res_t;

  // low bits of the element count as carried on the result beat
  function automatic logic [TOTAL_W-1:0] count_to_total(input logic [CW-1:0] cnt);
    logic [CW+TOTAL_W-1:0] ext;
    ext = {{TOTAL_W{1'b0}}, cnt};
    return ext[TOTAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pls_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ctrl
// operation sequencer: checks each beat, moves elements through the store
// one per cycle and produces the result
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pls_pkg::in_beat_t  in_data,
  output pls_pkg::pls_res_t       res,
  input  wire logic               res_ready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t                            state_r, state_nxt;
  logic                              ins_r, ins_nxt;
  logic [pls_pkg::AW-1:0]            k_r, k_nxt;
  logic [pls_pkg::AW-1:0]            cur_r, cur_nxt;
  logic [pls_pkg::CW-1:0]            rem_r, rem_nxt;
  logic                              pend_r, pend_nxt;
  logic                              pend_wr_r, pend_wr_nxt;
  logic [pls_pkg::AW-1:0]            pend_addr_r, pend_addr_nxt;
  logic signed [pls_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic signed [pls_pkg::VAL_W-1:0]  removed_r, removed_nxt;
  pls_pkg::status_t                  status_r, status_nxt;
  logic [pls_pkg::CW-1:0]            count_r, count_nxt;
  logic [pls_pkg::CW-1:0]            count_new_r, count_new_nxt;

  logic [pls_pkg::PW-1:0]            n_ext, p_ext;
  logic [pls_pkg::PW-1:0]            k_ext;
  logic                              pos_bad;
  pls_pkg::status_t                  chk_status;

  logic                              ram_we;
  logic [pls_pkg::AW-1:0]            ram_waddr;
  logic [pls_pkg::VAL_W-1:0]         ram_wdata;
  logic [pls_pkg::VAL_W-1:0]         ram_rdata;

  pls_ram #(
    .WIDTH (pls_pkg::VAL_W),
    .DEPTH (pls_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_r),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);

  // position checks on the incoming beat
  always_comb begin
    n_ext = pls_pkg::PW'(count_r);
    p_ext = pls_pkg::PW'(in_data.position);
    k_ext = p_ext - pls_pkg::PW'(1);
    if (in_data.kind == pls_pkg::KIND_INSERT) begin
      pos_bad = (p_ext == '0) || (p_ext > n_ext + pls_pkg::PW'(1));
      priority if (count_r >= pls_pkg::CW'(pls_pkg::CAPACITY)) begin
        chk_status = pls_pkg::STATUS_FULL;
      end else if (pos_bad) begin
        chk_status = pls_pkg::STATUS_BADPOS;
      end else begin
        chk_status = pls_pkg::STATUS_OK;
      end
    end else begin
      pos_bad = (p_ext == '0) || (p_ext > n_ext);
      priority if (count_r == '0) begin
        chk_status = pls_pkg::STATUS_EMPTY;
      end else if (pos_bad) begin
        chk_status = pls_pkg::STATUS_BADPOS;
      end else begin
        chk_status = pls_pkg::STATUS_OK;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ins_nxt       = ins_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    pend_wr_nxt   = pend_wr_r;
    pend_addr_nxt = pend_addr_r;
    val_nxt       = val_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    count_new_nxt = count_new_r;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = ram_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ins_nxt     = (in_data.kind == pls_pkg::KIND_INSERT);
          k_nxt       = k_ext[pls_pkg::AW-1:0];
          val_nxt     = in_data.value;
          removed_nxt = '0;
          status_nxt  = chk_status;
          // reads needed: count minus zero-based position, for both kinds
          rem_nxt     = pls_pkg::CW'(n_ext - k_ext);
          if (in_data.kind == pls_pkg::KIND_INSERT) begin
            cur_nxt       = pls_pkg::AW'(count_r - pls_pkg::CW'(1));
            count_new_nxt = count_r + pls_pkg::CW'(1);
          end else begin
            cur_nxt       = k_ext[pls_pkg::AW-1:0];
            count_new_nxt = count_r - pls_pkg::CW'(1);
          end
          if (chk_status == pls_pkg::STATUS_OK) begin
            state_nxt = ST_SHIFT;
          end else begin
            count_new_nxt = count_r;
            state_nxt     = ST_DONE;
          end
        end
      end

      ST_SHIFT: begin
        // data read last cycle lands here
        if (pend_r) begin
          if (pend_wr_r) begin
            ram_we = 1'b1;
          end else begin
            removed_nxt = ram_rdata;
          end
        end
        if (rem_r != '0) begin
          pend_nxt = 1'b1;
          rem_nxt  = rem_r - pls_pkg::CW'(1);
          if (ins_r) begin
            pend_addr_nxt = cur_r + pls_pkg::AW'(1);
            pend_wr_nxt   = 1'b1;
            cur_nxt       = cur_r - pls_pkg::AW'(1);
          end else begin
            // first read of a delete fetches the removed element
            pend_addr_nxt = cur_r - pls_pkg::AW'(1);
            pend_wr_nxt   = (cur_r != k_r);
            cur_nxt       = cur_r + pls_pkg::AW'(1);
          end
        end else if (!pend_r) begin
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_waddr = k_r;
            ram_wdata = val_r;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          count_nxt = count_new_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.valid              = (state_r == ST_DONE);
    res.beat.status        = status_r;
    res.beat.removed_value = removed_r;
    res.beat.element_total = pls_pkg::count_to_total(count_new_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
    end
    ins_r       <= ins_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    pend_wr_r   <= pend_wr_nxt;
    pend_addr_r <= pend_addr_nxt;
    val_r       <= val_nxt;
    removed_r   <= removed_nxt;
    status_r    <= status_nxt;
    count_new_r <= count_new_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/positional_list_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed 32-bit values with insert and delete by position
// ----------------------------------------------------------------------------
//  channel  handshake             payload               direction
//  in       in_valid / in_ready   in_data  (in_beat_t)  input
//  out      out_valid / out_ready out_data (out_beat_t) output
//
//  an insert or delete at 1-based position p on a list of n elements moves
//  n-p+1 entries through the store ram, one per cycle over its single read
//  and write port; an error moves nothing. reset clears only the count,
//  with no ram sweep.
//  a finished result sits in the output register; the next beat is taken
//  while it waits and only its own result stalls behind an unread one.
// ----------------------------------------------------------------------------
module positional_list_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pls_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pls_pkg::out_beat_t      out_data
);

  pls_pkg::pls_res_t  res;
  logic               res_ready;
  logic               out_valid_r;
  pls_pkg::out_beat_t out_data_r;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res       (res),
    .res_ready (res_ready)
  );

  // output slot is free when empty or emptied this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_data_r <= res.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb_positional_list_store.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_store
// checks insert and delete by position against a shadow copy of the list
// ----------------------------------------------------------------------------
//  a short directed run covers the error codes and the list ends. A fill to
//  capacity follows, then a random walk of the element count towards random
//  targets with some noise mixed in. Every accepted beat is applied to the
//  shadow list and the outcome is queued. Result beats are checked in order.
// ----------------------------------------------------------------------------
module tb_positional_list_store;

  localparam int SETTLE_CYCLES = 80;
  localparam int STIM_ITEMS    = 1700;
  localparam int HOLD_CYCLES   = 500;

  typedef struct {
    pls_pkg::in_beat_t beat;
    bit                drain_first;
  } queued_op_t;

  typedef enum logic [1:0] {
    READY_STEADY,
    READY_COIN,
    READY_SPARSE
  } ready_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pls_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pls_pkg::out_beat_t out_data;

  queued_op_t         op_backlog[$];
  pls_pkg::out_beat_t pending_outcomes[$];

  // shadow of the list contents and element count
  logic signed [pls_pkg::VAL_W-1:0] shadow_list [pls_pkg::CAPACITY];
  int shadow_count = 0;

  // element count as seen while building the stimulus
  int gen_count = 0;

  int mismatch_count = 0;
  int beats_accepted = 0;
  int results_checked = 0;
  int outstanding = 0;

  positional_list_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // applies one beat to the shadow list and returns its outcome
  task automatic edit_shadow_list(input pls_pkg::in_beat_t op,
                                  output pls_pkg::out_beat_t res);
    int p;
    p = op.position;
    res.status = pls_pkg::STATUS_OK;
    res.removed_value = '0;
    if (op.kind == pls_pkg::KIND_INSERT) begin
      if (shadow_count >= pls_pkg::CAPACITY) begin
        res.status = pls_pkg::STATUS_FULL;
      end else if (p < 1 || p > shadow_count + 1) begin
        res.status = pls_pkg::STATUS_BADPOS;
      end else begin
        for (int i = shadow_count; i > p - 1; i--) begin
          shadow_list[i] = shadow_list[i-1];
        end
        shadow_list[p-1] = op.value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = pls_pkg::STATUS_EMPTY;
      end else if (p < 1 || p > shadow_count) begin
        res.status = pls_pkg::STATUS_BADPOS;
      end else begin
        res.removed_value = shadow_list[p-1];
        for (int i = p - 1; i + 1 < shadow_count; i++) begin
          shadow_list[i] = shadow_list[i+1];
        end
        shadow_count--;
      end
    end
    res.element_total = pls_pkg::TOTAL_W'(shadow_count);
  endtask

  function automatic void add_op(input logic kind, input int pos,
                                 input logic signed [pls_pkg::VAL_W-1:0] value,
                                 input bit drain_first = 1'b0);
    queued_op_t q;
    q.beat.kind = kind;
    q.beat.position = pls_pkg::POS_W'(pos);
    q.beat.value = value;
    q.drain_first = drain_first;
    op_backlog.push_back(q);
    if (kind == pls_pkg::KIND_INSERT) begin
      if (gen_count < pls_pkg::CAPACITY && pos >= 1 && pos <= gen_count + 1) gen_count++;
    end else begin
      if (gen_count > 0 && pos >= 1 && pos <= gen_count) gen_count--;
    end
  endfunction

  function automatic logic signed [pls_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // legal position with the ends favoured; empty list gets a near-zero one
  function automatic int pick_position(input bit grow);
    int top;
    top = grow ? gen_count + 1 : gen_count;
    if (top == 0) return $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: return 1;
      1: return top;
      default: return $urandom_range(1, top);
    endcase
  endfunction

  // sender: bursts of beats with random gaps, optional drain before a beat
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (op_backlog[0].drain_first && (in_valid || outstanding != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= op_backlog.pop_front().beat;
        in_valid <= 1'b1;
        burst_left--;
      end
    end
  end

  // receiver: random ready modes plus occasional long hold-offs
  int hold_left = 0;
  int next_hold_at = 150;
  int mode_left = 0;
  ready_mode_t ready_mode = READY_STEADY;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (results_checked >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at = next_hold_at + 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(5, 80);
        end
        mode_left--;
        case (ready_mode)
          READY_STEADY: out_ready <= 1'b1;
          READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
          default:      out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: checks result beats, then predicts from accepted input beats
  always @(posedge clk) begin
    pls_pkg::out_beat_t want;
    pls_pkg::out_beat_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: %p", got));
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %s, expected %s",
                                      got.status.name(), want.status.name()));
          if (got.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value %0d, expected %0d",
                                      got.removed_value, want.removed_value));
          if (got.element_total !== want.element_total)
            report_mismatch($sformatf("element_total %0d, expected %0d",
                                      got.element_total, want.element_total));
        end
        results_checked <= results_checked + 1;
      end
      if (in_valid && in_ready) begin
        edit_shadow_list(in_data, want);
        pending_outcomes.push_back(want);
        beats_accepted <= beats_accepted + 1;
      end
      outstanding <= outstanding + int'(in_valid && in_ready) - int'(out_valid && out_ready);
    end
  end

  initial begin
    int total_ops;
    int target;
    int span;
    bit grow;
    bit drain_next;

    // errors on an empty list, empty takes precedence over position
    add_op(pls_pkg::KIND_DELETE, 1, '0);
    add_op(pls_pkg::KIND_DELETE, 0, '0);
    add_op(pls_pkg::KIND_INSERT, 0, 32'sd5);
    add_op(pls_pkg::KIND_INSERT, 2, 32'sd6);
    add_op(pls_pkg::KIND_INSERT, 127, 32'sd7);
    // front, append and middle inserts with extreme values
    add_op(pls_pkg::KIND_INSERT, 1, 32'sh7fffffff);
    add_op(pls_pkg::KIND_INSERT, 2, 32'sh80000000);
    add_op(pls_pkg::KIND_INSERT, 1, -32'sd1);
    add_op(pls_pkg::KIND_INSERT, 2, '0);
    add_op(pls_pkg::KIND_INSERT, 6, 32'sd9);
    add_op(pls_pkg::KIND_INSERT, 5, 32'sh55555555);
    add_op(pls_pkg::KIND_DELETE, 0, '0);
    add_op(pls_pkg::KIND_DELETE, 6, '0);
    add_op(pls_pkg::KIND_DELETE, 127, 32'shaaaaaaaa);
    add_op(pls_pkg::KIND_DELETE, 1, '0);
    add_op(pls_pkg::KIND_DELETE, 4, '0);
    add_op(pls_pkg::KIND_DELETE, 2, '0);
    add_op(pls_pkg::KIND_INSERT, 1, 32'shaaaaaaaa);
    while (gen_count > 0) add_op(pls_pkg::KIND_DELETE, gen_count, '0);

    // fill to capacity, then the full-list cases
    add_op(pls_pkg::KIND_INSERT, 1, pick_value(), 1'b1);
    while (gen_count < pls_pkg::CAPACITY)
      add_op(pls_pkg::KIND_INSERT, pick_position(1'b1), pick_value());
    add_op(pls_pkg::KIND_INSERT, 1, pick_value());
    add_op(pls_pkg::KIND_INSERT, 0, pick_value());
    add_op(pls_pkg::KIND_INSERT, pls_pkg::CAPACITY + 1, pick_value());
    add_op(pls_pkg::KIND_DELETE, pls_pkg::CAPACITY + 1, '0);
    add_op(pls_pkg::KIND_DELETE, pls_pkg::CAPACITY, '0);
    add_op(pls_pkg::KIND_INSERT, pls_pkg::CAPACITY, pick_value());
    add_op(pls_pkg::KIND_DELETE, 1, '0);

    // random walk of the count towards random targets
    drain_next = 1'b1;
    while (op_backlog.size() < STIM_ITEMS) begin
      target = $urandom_range(0, pls_pkg::CAPACITY);
      span = $urandom_range(4, 60);
      for (int k = 0; k < span; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_op(1'($urandom_range(0, 1)), $urandom_range(0, 127), $urandom,
                 drain_next && k == 0);
        end else begin
          grow = (gen_count < target);
          if ($urandom_range(0, 4) == 0) grow = !grow;
          if (gen_count == target) grow = 1'($urandom_range(0, 1));
          add_op(grow ? pls_pkg::KIND_INSERT : pls_pkg::KIND_DELETE,
                 pick_position(grow), pick_value(), drain_next && k == 0);
        end
      end
      drain_next = ($urandom_range(0, 7) == 0);
    end
    total_ops = op_backlog.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_accepted != total_ops || outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_positional_list_store: PASS");
    end else begin
      $display("tb_positional_list_store: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_positional_list_store: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_ctrl.sv
rtl/positional_list_store.sv
tb/sv/tb_positional_list_store.sv
